// File: hw/rtl/kdlp_pkg.sv
// Shared types and constants of the key debounce / long-press block.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package kdlp_pkg;

	localparam int NUM_KEYS  = 3;
	localparam int KEY_W     = 2;
	localparam int PIN_W     = 3;
	localparam int TIME_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd1;

	localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = 16'd20;
	localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 16'd1000;

	// Item function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_EDGE = 1'b1;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_LONG    = 2'd2
	} ev_kind_t;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key_select;
		logic [PIN_W-1:0] pin_levels;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] event_key;
		logic [1:0]       event_kind;
		logic             last_event;
	} evt_t;

	// Events raised by one item, one slot per key, in key order
	typedef struct packed {
		logic     [NUM_KEYS-1:0] fire;
		ev_kind_t [NUM_KEYS-1:0] kind;
	} ev_set_t;

endpackage

`default_nettype wire

// File: hw/rtl/key_debounce_long_press.sv
// Top level of the key debounce / long-press block: input register,
// configuration registers, key core and event result register.
// Depends on kdlp_pkg, kdlp_core and kdlp_evbuf.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): one item per accepted edge,
//     either a timer tick or a pin edge on cmd.key_select, with the pin
//     levels of all three keys (low = pressed).
//   evt channel (evt_valid / evt_stall / evt): one press, release or
//     long-press event per transfer; evt.last_event marks the final event of
//     the item that caused it. Items with no event produce nothing.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//     debounce and long-press thresholds; always ready. Write only while
//     the block is idle.
// Timing: an accepted item waits in the input register until the event
//   register can take it; it is then evaluated and stored there, and its
//   events show from the event register. One item per cycle is taken when
//   it raises at most one event and evt is not stalled; an item raising
//   several events holds the event register until its last event moves,
//   since the evt port moves one event per cycle while evt is not stalled.
// Stall: while evt is stalled, events hold steady; the input register
//   fills and then cmd_stall rises until the event register drains.
// Reset: arst_n clears the tick counter, all keys to free, thresholds to
//   20 and 1000 ticks, and drops any pending item or event.
`default_nettype none

module key_debounce_long_press (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cmd_valid,
	output logic                             cmd_stall,
	input  kdlp_pkg::cmd_t                   cmd,
	output logic                             evt_valid,
	input  wire                              evt_stall,
	output kdlp_pkg::evt_t                   evt,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [kdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [kdlp_pkg::TIME_W-1:0]       cfg_data
);

	logic                        valid_s1;
	kdlp_pkg::cmd_t              cmd_s1;
	logic [kdlp_pkg::TIME_W-1:0] debounce_ticks_q;
	logic [kdlp_pkg::TIME_W-1:0] long_press_ticks_q;

	logic              can_load;
	logic              take;
	logic              accept;
	kdlp_pkg::ev_set_t ev_set;

	// item in s1 commits when the event register can take its events
	assign take      = valid_s1 && can_load;
	assign cmd_stall = valid_s1 && !can_load;
	assign accept    = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_s1 <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= kdlp_pkg::DEBOUNCE_RESET;
			long_press_ticks_q <= kdlp_pkg::LONG_PRESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			// indexes past the list are ignored
			if (cfg_index == kdlp_pkg::CFG_DEBOUNCE_TICKS)
				debounce_ticks_q <= cfg_data;
			if (cfg_index == kdlp_pkg::CFG_LONG_PRESS_TICKS)
				long_press_ticks_q <= cfg_data;
		end
	end

	kdlp_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.cmd_s1           (cmd_s1),
		.debounce_ticks   (debounce_ticks_q),
		.long_press_ticks (long_press_ticks_q),
		.ev_set           (ev_set)
	);

	kdlp_evbuf u_evbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.ev_set    (ev_set),
		.can_load  (can_load),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

endmodule

`default_nettype wire

// File: hw/rtl/kdlp_core.sv
// Key state registers, tick counter and per-key transition logic.
// Depends on kdlp_pkg.
`default_nettype none

module kdlp_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              take,
	input  kdlp_pkg::cmd_t                   cmd_s1,
	input  wire [kdlp_pkg::TIME_W-1:0]       debounce_ticks,
	input  wire [kdlp_pkg::TIME_W-1:0]       long_press_ticks,
	output kdlp_pkg::ev_set_t                ev_set
);

	typedef enum logic [1:0] {
		PH_FREE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_PRESSED  = 2'd2,
		PH_LONG     = 2'd3
	} phase_t;

	logic [kdlp_pkg::TIME_W-1:0] tick_q;
	phase_t                      phase_q [kdlp_pkg::NUM_KEYS];
	logic [kdlp_pkg::TIME_W-1:0] dbs_q   [kdlp_pkg::NUM_KEYS];
	logic [kdlp_pkg::TIME_W-1:0] prs_q   [kdlp_pkg::NUM_KEYS];

	logic [kdlp_pkg::TIME_W-1:0] tick_use;
	phase_t                      phase_d [kdlp_pkg::NUM_KEYS];
	logic [kdlp_pkg::NUM_KEYS-1:0] set_dbs;
	logic [kdlp_pkg::NUM_KEYS-1:0] set_prs;

	// A tick advances the counter before any key looks at it
	assign tick_use = (cmd_s1.func == kdlp_pkg::FUNC_TICK) ?
		tick_q + kdlp_pkg::TIME_W'(1) : tick_q;

	always_comb begin
		logic                        eval_k;
		logic                        pressed;
		logic [kdlp_pkg::TIME_W-1:0] el_db;
		logic [kdlp_pkg::TIME_W-1:0] el_pr;
		ev_set = '0;
		set_dbs = '0;
		set_prs = '0;
		for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin
			phase_d[k] = phase_q[k];
			if (cmd_s1.func == kdlp_pkg::FUNC_TICK)
				eval_k = (phase_q[k] == PH_DEBOUNCE) || (phase_q[k] == PH_PRESSED);
			else
				eval_k = (cmd_s1.key_select == kdlp_pkg::KEY_W'(k));
			pressed = ~cmd_s1.pin_levels[k];
			el_db = tick_use - dbs_q[k];
			el_pr = tick_use - prs_q[k];
			if (eval_k) begin
				unique case (phase_q[k])
					PH_FREE: begin
						if (pressed) begin
							phase_d[k] = PH_DEBOUNCE;
							set_dbs[k] = 1'b1;
						end
					end
					PH_DEBOUNCE: begin
						if (!pressed) begin
							phase_d[k] = PH_FREE;
						end else if (el_db >= debounce_ticks) begin
							phase_d[k] = PH_PRESSED;
							set_prs[k] = 1'b1;
							ev_set.fire[k] = 1'b1;
							ev_set.kind[k] = kdlp_pkg::EV_PRESS;
						end
					end
					PH_PRESSED: begin
						if (!pressed) begin
							phase_d[k] = PH_FREE;
							ev_set.fire[k] = 1'b1;
							ev_set.kind[k] = kdlp_pkg::EV_RELEASE;
						end else if (el_pr >= long_press_ticks) begin
							phase_d[k] = PH_LONG;
							ev_set.fire[k] = 1'b1;
							ev_set.kind[k] = kdlp_pkg::EV_LONG;
						end
					end
					PH_LONG: begin
						// release after long press is silent
						if (!pressed)
							phase_d[k] = PH_FREE;
					end
					default: phase_d[k] = PH_FREE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin
				phase_q[k] <= PH_FREE;
				dbs_q[k]   <= '0;
				prs_q[k]   <= '0;
			end
		end else if (take) begin
			tick_q <= tick_use;
			for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin
				phase_q[k] <= phase_d[k];
				if (set_dbs[k])
					dbs_q[k] <= tick_use;
				if (set_prs[k])
					prs_q[k] <= tick_use;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/kdlp_evbuf.sv
// Event result register: holds the events of one item and hands them out
// one per cycle in key order while evt is not stalled. Depends on kdlp_pkg.
`default_nettype none

module kdlp_evbuf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  kdlp_pkg::ev_set_t   ev_set,
	output logic                can_load,
	output logic                evt_valid,
	input  wire                 evt_stall,
	output kdlp_pkg::evt_t      evt
);

	logic [kdlp_pkg::NUM_KEYS-1:0] pend_q;
	kdlp_pkg::ev_kind_t [kdlp_pkg::NUM_KEYS-1:0] kind_q;

	logic [kdlp_pkg::NUM_KEYS-1:0] sel_oh;
	logic [kdlp_pkg::KEY_W-1:0]    sel_key;
	logic                          pop;

	// lowest pending key goes first
	always_comb begin
		logic found;
		found = 1'b0;
		sel_oh = '0;
		sel_key = '0;
		for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin
			if (pend_q[k] && !found) begin
				found = 1'b1;
				sel_oh[k] = 1'b1;
				sel_key = kdlp_pkg::KEY_W'(k);
			end
		end
	end

	assign evt_valid      = |pend_q;
	assign pop            = evt_valid && !evt_stall;
	assign evt.event_key  = sel_key;
	assign evt.event_kind = kind_q[sel_key];
	assign evt.last_event = ((pend_q & ~sel_oh) == '0);
	assign can_load       = !evt_valid || (pop && evt.last_event);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= ev_set.fire;
		end else if (pop) begin
			pend_q <= pend_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			kind_q <= ev_set.kind;
	end

endmodule

`default_nettype wire

// File: dv/key_debounce_long_press_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of key_debounce_long_press: a queue-fed driver offers
// tick and edge items, a behavioral key model predicts the events and a
// monitor checks them in order. Depends on kdlp_pkg and the block's RTL.

module key_debounce_long_press_tb;

	localparam int CLK_HIGH      = 4;
	localparam int CLK_LOW       = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int MAX_EVENTS    = 3;
	// Settling pause after the block drains; covers a silent item still in flight
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam logic [kdlp_pkg::TIME_W-1:0] TIME_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		KEY_FREE     = 2'd0,
		KEY_DEBOUNCE = 2'd1,
		KEY_PRESSED  = 2'd2,
		KEY_LONG     = 2'd3
	} key_phase_t;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           cmd_valid  = 1'b0;
	logic                           cmd_stall;
	kdlp_pkg::cmd_t                 cmd        = '0;
	logic                           evt_valid;
	logic                           evt_stall  = 1'b0;
	kdlp_pkg::evt_t                 evt;
	logic                           cfg_valid  = 1'b0;
	logic                           cfg_ready;
	logic [kdlp_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
	logic [kdlp_pkg::TIME_W-1:0]    cfg_data   = '0;

	key_debounce_long_press u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW  clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Key model: thresholds, tick counter and per-key phase
	// ---------------------------------------------------------------------
	logic [kdlp_pkg::TIME_W-1:0] debounce_thr = kdlp_pkg::DEBOUNCE_RESET;
	logic [kdlp_pkg::TIME_W-1:0] long_thr     = kdlp_pkg::LONG_PRESS_RESET;
	logic [kdlp_pkg::TIME_W-1:0] tick_count   = '0;
	key_phase_t                  key_phase [kdlp_pkg::NUM_KEYS];
	logic [kdlp_pkg::TIME_W-1:0] db_start  [kdlp_pkg::NUM_KEYS];
	logic [kdlp_pkg::TIME_W-1:0] pr_start  [kdlp_pkg::NUM_KEYS];

	kdlp_pkg::evt_t step_events [$];   // events of the item under evaluation
	kdlp_pkg::evt_t exp_events  [$];   // events still owed by the block, oldest first
	kdlp_pkg::cmd_t pending_cmds[$];   // items not yet offered

	int   n_mismatch = 0;
	int   n_sent     = 0;    // items put on the cmd port
	int   n_taken    = 0;    // items accepted by the block
	int   idle_pct   = 10;
	logic hold_go    = 1'b0;
	logic hold_on    = 1'b0;
	logic [kdlp_pkg::NUM_KEYS-1:0] held_keys = '0;  // generator's view: 1 = finger down
	kdlp_pkg::evt_t want_evt;

	initial begin
		for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin
			key_phase[k] = KEY_FREE;
			db_start[k]  = '0;
			pr_start[k]  = '0;
		end
	end

	function automatic void push_event(int k, kdlp_pkg::ev_kind_t kind);
		// events beyond the per-item cap are dropped; state still moves
		if (step_events.size() < MAX_EVENTS)
			step_events.push_back('{event_key: kdlp_pkg::KEY_W'(k), event_kind: kind,
				last_event: 1'b0});
	endfunction

	function automatic void advance_key(int k, logic [kdlp_pkg::PIN_W-1:0] pins);
		logic                        down;
		logic [kdlp_pkg::TIME_W-1:0] elapsed;
		down = (k < kdlp_pkg::PIN_W) ? (pins[k] == 1'b0) : 1'b0;
		case (key_phase[k])
			KEY_FREE: begin
				if (down) begin
					key_phase[k] = KEY_DEBOUNCE;
					db_start[k]  = tick_count;
				end
			end
			KEY_DEBOUNCE: begin
				elapsed = tick_count - db_start[k];
				if (!down) begin
					key_phase[k] = KEY_FREE;
				end else if (elapsed >= debounce_thr) begin
					key_phase[k] = KEY_PRESSED;
					pr_start[k]  = tick_count;
					push_event(k, kdlp_pkg::EV_PRESS);
				end
			end
			KEY_PRESSED: begin
				elapsed = tick_count - pr_start[k];
				if (!down) begin
					key_phase[k] = KEY_FREE;
					push_event(k, kdlp_pkg::EV_RELEASE);
				end else if (elapsed >= long_thr) begin
					key_phase[k] = KEY_LONG;
					push_event(k, kdlp_pkg::EV_LONG);
				end
			end
			default: begin
				// release after a long press is silent
				if (!down)
					key_phase[k] = KEY_FREE;
			end
		endcase
	endfunction

	task automatic predict_events(kdlp_pkg::cmd_t c);
		step_events.delete();
		if (c.func == kdlp_pkg::FUNC_TICK) begin
			tick_count = tick_count + 1'b1;
			// ticks only look at keys that are timing something
			for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++)
				if (key_phase[k] == KEY_DEBOUNCE || key_phase[k] == KEY_PRESSED)
					advance_key(k, c.pin_levels);
		end else if (c.key_select < kdlp_pkg::NUM_KEYS) begin
			advance_key(int'(c.key_select), c.pin_levels);
		end
		if (step_events.size() > 0)
			step_events[step_events.size()-1].last_event = 1'b1;
		foreach (step_events[i])
			exp_events.push_back(step_events[i]);
	endtask

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		n_mismatch++;
	endtask

	// ---------------------------------------------------------------------
	// Rising edge: check the event port, then model any accepted item
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_valid === 1'b1 && evt_stall == 1'b0) begin
				if (exp_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event key %0d kind %0d last %0b",
						evt.event_key, evt.event_kind, evt.last_event));
				end else begin
					want_evt = exp_events.pop_front();
					if (evt.event_key !== want_evt.event_key)
						report_mismatch($sformatf("event_key %0d, expected %0d",
							evt.event_key, want_evt.event_key));
					if (evt.event_kind !== want_evt.event_kind)
						report_mismatch($sformatf("event_kind %0d, expected %0d (key %0d)",
							evt.event_kind, want_evt.event_kind, want_evt.event_key));
					if (evt.last_event !== want_evt.last_event)
						report_mismatch($sformatf("last_event %0b, expected %0b (key %0d)",
							evt.last_event, want_evt.last_event, want_evt.event_key));
				end
			end
			if (cmd_valid && cmd_stall === 1'b0) begin
				predict_events(cmd);
				n_taken++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Falling edge: item driver. An offered item holds until it is taken.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !(cmd_valid && n_taken != n_sent)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cmd       <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
				n_sent++;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Event receiver: random stall, plus the long hold-off when asked
	always @(negedge clk)
		evt_stall <= hold_on || ($urandom_range(99) < idle_pct);

	// Long hold-off so the event register backs up into cmd_stall
	initial begin
		wait (hold_go);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on = 1'b0;
	end

	// Run limit
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("key_debounce_long_press_tb: FAIL");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic kdlp_pkg::cmd_t mk_cmd(logic f, logic [kdlp_pkg::KEY_W-1:0] k,
		logic [kdlp_pkg::PIN_W-1:0] p);
		return '{func: f, key_select: k, pin_levels: p};
	endfunction

	task automatic write_cfg(logic [kdlp_pkg::CFG_IDX_W-1:0] idx,
		logic [kdlp_pkg::TIME_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == kdlp_pkg::CFG_DEBOUNCE_TICKS)
			debounce_thr = val;
		else if (idx == kdlp_pkg::CFG_LONG_PRESS_TICKS)
			long_thr = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Block idle: everything offered, taken and answered, then a short pause
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || cmd_valid || exp_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly plausible key activity: fingers go down and up on edge items,
	// ticks carry the held levels. A few items are pure noise (bounces,
	// unknown key numbers, levels that disagree with the last edge).
	task automatic queue_random(int n, int edge_pct);
		int r;
		int k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				pending_cmds.push_back(mk_cmd(1'($urandom_range(1)),
					kdlp_pkg::KEY_W'($urandom_range(3)),
					kdlp_pkg::PIN_W'($urandom_range(7))));
			end else if (r < 8 + edge_pct) begin
				k = $urandom_range(kdlp_pkg::NUM_KEYS-1);
				held_keys[k] = ~held_keys[k];
				pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, kdlp_pkg::KEY_W'(k),
					~held_keys));
			end else begin
				// key_select is don't-care on ticks
				pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_TICK,
					kdlp_pkg::KEY_W'($urandom_range(3)), ~held_keys));
			end
		end
	endtask

	task automatic release_all();
		held_keys = '0;
		for (int k = 0; k < kdlp_pkg::NUM_KEYS; k++)
			pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, kdlp_pkg::KEY_W'(k),
				3'b111));
	endtask

	// ---------------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, zero thresholds: every event fires on the first look
		write_cfg(kdlp_pkg::CFG_DEBOUNCE_TICKS, '0);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS_TICKS, '0);
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd0, 3'b110)); // free -> debounce
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd0, 3'b110)); // press
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd0, 3'b110)); // long press
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd0, 3'b110)); // held: nothing
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd0, 3'b111)); // silent release
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd3, 3'b000)); // key out of range
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd1, 3'b000));
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd2, 3'b000));
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd0, 3'b000)); // all in debounce
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_TICK, 2'd3, 3'b000)); // three presses
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_TICK, 2'd0, 3'b000)); // three long presses
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_TICK, 2'd0, 3'b000)); // skip long keys
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd0, 3'b111));
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd1, 3'b111));
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd2, 3'b111)); // all free again
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd1, 3'b101)); // debounce
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_TICK, 2'd1, 3'b101)); // press
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_TICK, 2'd2, 3'b111)); // release event
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd2, 3'b011)); // debounce
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_TICK, 2'd0, 3'b111)); // bounce: silent
		pending_cmds.push_back(mk_cmd(kdlp_pkg::FUNC_EDGE, 2'd1, 3'b111)); // free key released
		wait_idle();

		// Short thresholds: lots of full press / release / long sequences
		write_cfg(kdlp_pkg::CFG_DEBOUNCE_TICKS, 16'd3);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS_TICKS, 16'd5);
		queue_random(55, 25);
		wait_idle();

		// Zero thresholds with no idling on either side
		idle_pct = 0;
		write_cfg(kdlp_pkg::CFG_DEBOUNCE_TICKS, '0);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS_TICKS, '0);
		queue_random(45, 30);
		wait_idle();
		idle_pct = 10;

		// Long press out of reach
		write_cfg(kdlp_pkg::CFG_DEBOUNCE_TICKS, 16'd2);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS_TICKS, TIME_MAX);
		queue_random(35, 25);
		wait_idle();

		// Receiver holds off while items keep coming
		write_cfg(kdlp_pkg::CFG_DEBOUNCE_TICKS, 16'd1);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS_TICKS, 16'd2);
		@(posedge clk);
		hold_go = 1'b1;
		queue_random(55, 30);
		wait_idle();

		// Back to the power-on thresholds
		write_cfg(kdlp_pkg::CFG_DEBOUNCE_TICKS, kdlp_pkg::DEBOUNCE_RESET);
		write_cfg(kdlp_pkg::CFG_LONG_PRESS_TICKS, kdlp_pkg::LONG_PRESS_RESET);
		release_all();
		wait_idle();

		if (n_mismatch == 0)
			$display("key_debounce_long_press_tb: PASS");
		else
			$display("key_debounce_long_press_tb: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/kdlp_pkg.sv
hw/rtl/kdlp_core.sv
hw/rtl/kdlp_evbuf.sv
hw/rtl/key_debounce_long_press.sv
dv/key_debounce_long_press_tb.sv
